// ----- rtl/core/slemc_pkg.sv -----
// package for the serial line editor with masked check
// holds payload structs, register indexes, character codes and sizes
// no dependencies
package slemc_pkg;

    localparam int LINE_MAX_DEF = 255;
    localparam int REF_MAX_DEF  = 8;
    localparam int MAX_RES      = 3;
    localparam int RES_CNT_W    = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int REF_LEN_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_USER_REF     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USER_REF_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_REF     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_REF_LEN = 2'd3;

    localparam logic [CFG_DATA_W-1:0] REF_RESET     = 64'd474214788972;
    localparam logic [REF_LEN_W-1:0]  REF_LEN_RESET = 4'd5;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       mode;
    } t_in;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
        logic       line_done;
        logic       line_full;
        logic       line_match;
        logic [7:0] line_length;
    } t_out;

    typedef struct packed {
        logic [7:0] count;
        logic [1:0] skip;
    } t_edit_state;

endpackage

// ----- rtl/core/slemc_edit.sv -----
// combinational line edit step: next state, echo items and match check
// depends on slemc_pkg
module slemc_edit #(
    parameter int LINE_MAX = slemc_pkg::LINE_MAX_DEF,
    parameter int REF_MAX  = slemc_pkg::REF_MAX_DEF
) (
    input  slemc_pkg::t_in                        i_item,
    input  slemc_pkg::t_edit_state                i_state,
    input  logic [7:0]                            i_prefix [REF_MAX],
    input  logic [slemc_pkg::CFG_DATA_W-1:0]      i_user_ref,
    input  logic [slemc_pkg::REF_LEN_W-1:0]       i_user_len,
    input  logic [slemc_pkg::CFG_DATA_W-1:0]      i_pass_ref,
    input  logic [slemc_pkg::REF_LEN_W-1:0]       i_pass_len,
    output slemc_pkg::t_edit_state                o_state,
    output logic [7:0]                            o_prefix [REF_MAX],
    output slemc_pkg::t_out                       o_res [slemc_pkg::MAX_RES],
    output logic [slemc_pkg::RES_CNT_W-1:0]       o_nres
);

    logic [7:0]                         c;
    logic [7:0]                         echo;
    logic [8:0]                         inc;
    logic [7:0]                         cmp_count;
    logic                               is_eol;
    logic [slemc_pkg::CFG_DATA_W-1:0]   sel_ref;
    logic [slemc_pkg::REF_LEN_W-1:0]    sel_len;
    logic                               match;

    assign c       = i_item.rx_byte;
    assign echo    = i_item.mode ? c : slemc_pkg::CH_STAR;
    assign inc     = {1'b0, i_state.count} + 9'd1;
    assign is_eol  = (c == slemc_pkg::CH_CR) || (c == slemc_pkg::CH_LF);
    assign sel_ref = i_item.mode ? i_user_ref : i_pass_ref;
    assign sel_len = i_item.mode ? i_user_len : i_pass_len;
    assign cmp_count = is_eol ? i_state.count : inc[7:0];

    // prefix with the new character, stored only while below the prefix depth
    always_comb begin
        for (int k = 0; k < REF_MAX; k++) begin
            o_prefix[k] = i_prefix[k];
            if (i_state.skip == 2'd0 && c != slemc_pkg::CH_ESC && !is_eol &&
                c != slemc_pkg::CH_BS && c != slemc_pkg::CH_DEL &&
                i_state.count == 8'(k)) begin
                o_prefix[k] = c;
            end
        end
    end

    always_comb begin
        match = (sel_len <= slemc_pkg::REF_LEN_W'(REF_MAX)) &&
                (cmp_count == {4'd0, sel_len});
        for (int k = 0; k < REF_MAX; k++) begin
            if (slemc_pkg::REF_LEN_W'(k) < sel_len && o_prefix[k] != sel_ref[8*k +: 8]) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        o_state = i_state;
        o_nres  = '0;
        for (int k = 0; k < slemc_pkg::MAX_RES; k++) begin
            o_res[k] = '0;
        end
        priority if (i_state.skip != 2'd0) begin
            o_state.skip = i_state.skip - 2'd1;
        end else if (c == slemc_pkg::CH_ESC) begin
            o_state.skip = 2'd2;
        end else if (is_eol) begin
            o_res[0] = '{slemc_pkg::CH_CR, 1'b0, 1'b1, 1'b0, match, i_state.count};
            o_res[1] = '{slemc_pkg::CH_LF, 1'b1, 1'b1, 1'b0, match, i_state.count};
            o_state.count = '0;
            o_nres = 2'd2;
        end else if (c == slemc_pkg::CH_BS || c == slemc_pkg::CH_DEL) begin
            if (i_state.count != 8'd0) begin
                o_state.count = i_state.count - 8'd1;
                o_res[0] = '{slemc_pkg::CH_BS, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0};
                o_res[1] = '{slemc_pkg::CH_SPACE, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0};
                o_res[2] = '{slemc_pkg::CH_BS, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0};
                o_nres = 2'd3;
            end
        end else if (inc >= 9'(LINE_MAX)) begin
            o_res[0] = '{echo, 1'b0, 1'b1, 1'b1, match, inc[7:0]};
            o_res[1] = '{slemc_pkg::CH_CR, 1'b0, 1'b1, 1'b1, match, inc[7:0]};
            o_res[2] = '{slemc_pkg::CH_LF, 1'b1, 1'b1, 1'b1, match, inc[7:0]};
            o_state.count = '0;
            o_nres = 2'd3;
        end else begin
            o_res[0] = '{echo, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0};
            o_state.count = inc[7:0];
            o_nres = 2'd1;
        end
    end

endmodule

// ----- rtl/core/serial_line_editor_masked_check_unit.sv -----
// top level of the serial line editor with masked echo and word check
// depends on slemc_pkg and slemc_edit
//
// Each received byte is taken into an input register and edited in one pass;
// its echo items (none to three) are loaded into a three-entry output shift
// register and sent one per cycle while i_ready is high. A byte that yields no
// echo does not use the output port; a byte with echoes holds the output port
// until each is accepted, as the port carries a single item at a time. The next
// byte is loaded in the cycle in which the last echo of the previous one is
// accepted. Configuration writes take effect at the next edge.
module serial_line_editor_masked_check_unit #(
    parameter int LINE_MAX = slemc_pkg::LINE_MAX_DEF,
    parameter int REF_MAX  = slemc_pkg::REF_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  slemc_pkg::t_in                      i_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output slemc_pkg::t_out                     o_out,
    input  logic                                i_cfg_we,
    input  logic [slemc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [slemc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic                                   r_in_valid;
    slemc_pkg::t_in                         r_in;
    slemc_pkg::t_edit_state                 r_state;
    slemc_pkg::t_edit_state                 n_state;
    logic [7:0]                             r_prefix [REF_MAX];
    logic [7:0]                             n_prefix [REF_MAX];
    slemc_pkg::t_out                        r_res [slemc_pkg::MAX_RES];
    slemc_pkg::t_out                        n_res [slemc_pkg::MAX_RES];
    logic [slemc_pkg::RES_CNT_W-1:0]        r_cnt;
    logic [slemc_pkg::RES_CNT_W-1:0]        n_nres;
    logic [slemc_pkg::CFG_DATA_W-1:0]       r_user_ref;
    logic [slemc_pkg::REF_LEN_W-1:0]        r_user_len;
    logic [slemc_pkg::CFG_DATA_W-1:0]       r_pass_ref;
    logic [slemc_pkg::REF_LEN_W-1:0]        r_pass_len;
    logic                                   out_fire;
    logic                                   load;

    assign o_valid  = (r_cnt != '0);
    assign o_out    = r_res[0];
    assign out_fire = o_valid && i_ready;
    assign load     = r_in_valid && ((r_cnt == '0) || (r_cnt == 2'd1 && out_fire));
    assign o_ready  = !r_in_valid || load;

    slemc_edit #(
        .LINE_MAX (LINE_MAX),
        .REF_MAX  (REF_MAX)
    ) u_edit (
        .i_item     (r_in),
        .i_state    (r_state),
        .i_prefix   (r_prefix),
        .i_user_ref (r_user_ref),
        .i_user_len (r_user_len),
        .i_pass_ref (r_pass_ref),
        .i_pass_len (r_pass_len),
        .o_state    (n_state),
        .o_prefix   (n_prefix),
        .o_res      (n_res),
        .o_nres     (n_nres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_user_ref <= slemc_pkg::REF_RESET;
            r_user_len <= slemc_pkg::REF_LEN_RESET;
            r_pass_ref <= slemc_pkg::REF_RESET;
            r_pass_len <= slemc_pkg::REF_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                slemc_pkg::REG_USER_REF:     r_user_ref <= i_cfg_data;
                slemc_pkg::REG_USER_REF_LEN: r_user_len <= i_cfg_data[slemc_pkg::REF_LEN_W-1:0];
                slemc_pkg::REG_PASS_REF:     r_pass_ref <= i_cfg_data;
                slemc_pkg::REG_PASS_REF_LEN: r_pass_len <= i_cfg_data[slemc_pkg::REF_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_cnt      <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (load) begin
                r_state <= n_state;
                r_cnt   <= n_nres;
            end else if (out_fire) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // payload: input register, prefix and echo shift register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_in;
        end
        if (load) begin
            r_prefix <= n_prefix;
            r_res    <= n_res;
        end else if (out_fire) begin
            for (int k = 0; k < slemc_pkg::MAX_RES - 1; k++) begin
                r_res[k] <= r_res[k+1];
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(slemc_pkg::MAX_RES))
        else $error("echo count out of range");

    a_last_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.last == (r_cnt == 2'd1)))
        else $error("last flag not on final echo item");

    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_state.skip != 2'd0) |=> (r_cnt == '0))
        else $error("skipped byte produced echo");

    a_count_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        9'({1'b0, r_state.count}) < 9'(LINE_MAX))
        else $error("line count reached maximum without ending line");
`endif

endmodule
